/* sv/nps_pkg.sv */
// Shared types and constants for the next-prime search block.
// No dependencies; imported by nps_divider and next_prime_search.
`default_nettype none

package nps_pkg;

    // Default width of the signed start value that takes part in the search.
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field and bus widths.
    localparam int START_W     = 32;
    localparam int PRIME_W     = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Status that the remainder unit returns to the sequencer.
    typedef struct packed {
        logic done;       // one-cycle pulse, the remainder is final
        logic rem_zero;   // the divisor divides the dividend exactly
    } t_div_stat;

endpackage

`default_nettype wire

/* sv/nps_divider.sv */
// Iterative restoring divider that produces only the remainder, one bit per cycle.
// Depends on nps_pkg for the status struct.
`default_nettype none

module nps_divider
    import nps_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output t_div_stat                   o_stat
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_divisor;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   r_rem_zero;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   div_ext;
    logic [VALUE_WIDTH-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_quo[VALUE_WIDTH-1]};
        div_ext = {1'b0, r_divisor};
        if (rem_sh >= div_ext) begin
            n_rem = VALUE_WIDTH'(rem_sh - div_ext);
        end else begin
            n_rem = VALUE_WIDTH'(rem_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_rem_zero <= 1'b0;
        end else begin
            // The done pulse follows the last shift-subtract step.
            r_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= CW'(VALUE_WIDTH);
                r_rem     <= '0;
                r_quo     <= i_dividend;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[VALUE_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy     <= 1'b0;
                    r_rem_zero <= (n_rem == '0);
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = r_rem_zero;

endmodule

`default_nettype wire

/* sv/next_prime_search.sv */
// Top level of the next-prime search: handshake, candidate/divisor sequencer, result register.
// Depends on nps_pkg and nps_divider.
`default_nettype none

// This block takes one signed start value per input item and returns one result item
// holding the smallest prime that is greater than or equal to it; any start value of one
// or less, negative values included, gives 2. Only the low VALUE_WIDTH bits of the start
// value are used, read as a two's complement number of that width. Candidates are tried
// in rising order, and each one is tested by trial division with divisors from 2 up to
// the square root of the candidate. The divisor square is kept up to date by adding
// 2d+1 each time the divisor steps, so no multiplier is needed. All divisions run on a
// single shared remainder unit that retires one quotient bit per cycle. Each trial
// division takes the square compare, the launch of the remainder unit, VALUE_WIDTH
// shift-subtract steps and the return of the result. The time for an item is therefore
// data dependent and grows with the total number of trial divisions over all candidates
// tried. Any start value near 2^31 ends on a prime that needs about 46000 divisions;
// small start values need far fewer, since the divisors stop at the square root.
// The block takes a new item only while its sequencer is idle; a finished result waits in
// its own output register, so the next item can be accepted while the previous result is
// still unread.
module next_prime_search
    import nps_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input items.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] start_value (signed)
    // Result items.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata    // [30:0] prime_found, [31] zero
);

    // Divisor width: the divisor never exceeds the square root of the candidate plus one.
    localparam int DW = VALUE_WIDTH / 2 + 2;
    // The divisor square may run just past the candidate before the loop ends.
    localparam int SW = VALUE_WIDTH + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_cand;
    logic [DW-1:0]          r_div;
    logic [SW-1:0]          r_sq;
    logic                   r_out_valid;
    logic [PRIME_W-1:0]     r_out_prime;
    logic                   r_div_start;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   start_small;
    logic                   out_free;
    logic                   sq_past;
    logic                   out_load;
    t_div_stat              div_stat;

    assign raw         = i_s_tdata[VALUE_WIDTH-1:0];
    // Negative values and the values zero and one all go straight to the candidate 2.
    assign start_small = raw[VALUE_WIDTH-1] || (raw <= VALUE_WIDTH'(1));
    assign out_free    = !r_out_valid || i_m_tready;
    // Once the divisor square exceeds the candidate, no divisor was found: it is prime.
    assign sq_past     = (r_sq > SW'(r_cand));
    // A prime is moved into the result register as soon as that register is free.
    assign out_load    = (r_state == S_CHECK) && sq_past && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            // The remainder unit is launched for every divisor that still needs a test.
            r_div_start <= (r_state == S_CHECK) && !sq_past;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cand  <= start_small ? VALUE_WIDTH'(2) : raw;
                        r_div   <= DW'(2);
                        r_sq    <= SW'(4);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (sq_past) begin
                        // Hold the prime here until the result register is free.
                        if (out_free) begin
                            r_out_prime <= PRIME_W'(r_cand);
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (div_stat.rem_zero) begin
                            // Composite: move to the next candidate and restart the divisors.
                            r_cand <= r_cand + 1'b1;
                            r_div  <= DW'(2);
                            r_sq   <= SW'(4);
                        end else begin
                            // (d+1)^2 = d^2 + 2d + 1
                            r_div <= r_div + 1'b1;
                            r_sq  <= r_sq + SW'({r_div, 1'b1});
                        end
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    nps_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_cand),
        .i_divisor  (VALUE_WIDTH'(r_div)),
        .o_stat     (div_stat)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_prime);

endmodule

`default_nettype wire
